// ===== rtl/core/trsc_pkg.sv =====
// Shared types, constants and helpers of the touch relay switch controller.
package trsc_pkg;

   // Register indexes on the configuration port.
   localparam int unsigned CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_CONFIRM_TIMEOUT = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LONG_PRESS      = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BLINK_HALF      = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_CONFIG_FAST     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CONFIG_EXIT     = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_HOLD            = 3'd5;

   // Reset values of the registers.
   localparam logic [15:0] RST_CONFIRM_TIMEOUT = 16'd20;
   localparam logic [15:0] RST_LONG_PRESS      = 16'd1500;
   localparam logic [15:0] RST_BLINK_HALF      = 16'd200;
   localparam logic [15:0] RST_CONFIG_FAST     = 16'd30000;
   localparam logic [15:0] RST_CONFIG_EXIT     = 16'd32000;
   localparam logic [15:0] RST_HOLD            = 16'd6000;

   // Serial characters understood by the controller.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_U     = 8'h55;

   // LED patterns.
   localparam logic [3:0] LED_ALL_ON = 4'd15;
   localparam logic [3:0] LED_BLINK  = 4'd7;
   localparam logic [3:0] LED_DARK   = 4'd0;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ACT_BYTE    = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_PRESS   = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      TX_NONE     = 2'd0,
      TX_ECHO     = 2'd1,
      TX_STATUS   = 2'd2,
      TX_ANNOUNCE = 2'd3
   } tx_kind_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [15:0] confirm_timeout_ticks;
      logic [15:0] long_press_ticks;
      logic [15:0] blink_half_ticks;
      logic [15:0] config_fast_ticks;
      logic [15:0] config_exit_ticks;
      logic [15:0] hold_ticks;
   } cfg_type;

   // One result word.
   typedef struct packed {
      logic [3:0]  led_pattern;
      logic [2:0]  relay_pattern;
      tx_kind_type tx_kind;
      logic [7:0]  tx_byte;
   } rsp_type;

   // Saturating increment of a 16-bit counter.
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

endpackage

// ===== rtl/core/trsc_csr.sv =====
// Configuration register file of the touch relay switch controller.
module trsc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [trsc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [15:0]                           csr_wdata,
   output trsc_pkg::cfg_type                     cfg
);
   import trsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CONFIRM_TIMEOUT: cfg_in.confirm_timeout_ticks = csr_wdata;
            CSR_LONG_PRESS:      cfg_in.long_press_ticks      = csr_wdata;
            CSR_BLINK_HALF:      cfg_in.blink_half_ticks      = csr_wdata;
            CSR_CONFIG_FAST:     cfg_in.config_fast_ticks     = csr_wdata;
            CSR_CONFIG_EXIT:     cfg_in.config_exit_ticks     = csr_wdata;
            CSR_HOLD:            cfg_in.hold_ticks            = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.confirm_timeout_ticks <= RST_CONFIRM_TIMEOUT;
         cfg_ff.long_press_ticks      <= RST_LONG_PRESS;
         cfg_ff.blink_half_ticks      <= RST_BLINK_HALF;
         cfg_ff.config_fast_ticks     <= RST_CONFIG_FAST;
         cfg_ff.config_exit_ticks     <= RST_CONFIG_EXIT;
         cfg_ff.hold_ticks            <= RST_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/trsc_core.sv =====
// Controller state and the single-pass event update of the touch relay switch.
module trsc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  trsc_pkg::cfg_type     cfg,
   input  logic                  step,
   input  trsc_pkg::action_type  action,
   input  logic [7:0]            rx_byte,
   input  logic [1:0]            button,
   input  logic [2:0]            pressed_mask,
   output trsc_pkg::rsp_type     rsp
);
   import trsc_pkg::*;

   typedef struct packed {
      logic [2:0]  channel_bits;
      logic [7:0]  pending_command;
      logic        request_open;
      logic        config_mode;
      logic [15:0] wait_count;
      logic [15:0] press_count;
      logic [15:0] phase_ticks;
      logic        blink_phase;
      logic [15:0] hold_count;
      logic [3:0]  led_now;
   } state_type;

   state_type   st_ff;
   state_type   st_in;
   tx_kind_type kind;
   logic [7:0]  txb;
   logic        is_digit;
   logic        is_confirm;
   logic        is_known;
   logic        pend_digit;
   logic [15:0] hold_dec;
   logic [15:0] wait_inc;
   logic [15:0] wait_inc2;
   logic [15:0] press_inc;
   logic [15:0] blink_inc;
   logic        exited;

   // Character classes of the received byte and of the pending command.
   assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_SEVEN);
   assign is_confirm = (rx_byte == CHAR_T) || (rx_byte == CHAR_F);
   assign is_known   = is_digit || is_confirm || (rx_byte == CHAR_U);
   assign pend_digit = (st_ff.pending_command >= CHAR_ZERO)
                       && (st_ff.pending_command <= CHAR_SEVEN);

   // Next state and result for the event now presented.
   always_comb begin
      st_in     = st_ff;
      kind      = TX_NONE;
      txb       = 8'd0;
      exited    = 1'b0;
      hold_dec  = st_ff.hold_count - 16'd1;
      wait_inc  = sat_inc(st_ff.wait_count);
      wait_inc2 = sat_inc(wait_inc);
      press_inc = sat_inc(st_ff.press_count);
      blink_inc = sat_inc(st_ff.phase_ticks);

      if (st_ff.hold_count != 16'd0) begin
         // Confirm pattern on hold: only ticks count it down.
         if (action == ACT_TICK) begin
            st_in.hold_count = hold_dec;
            if (hold_dec == 16'd0) begin
               st_in.config_mode  = 1'b0;
               st_in.request_open = 1'b0;
               st_in.led_now      = {1'b0, st_ff.channel_bits};
            end
         end
      end else begin
         unique case (action)
            ACT_BYTE: begin
               if (is_known) begin
                  if (!st_ff.request_open) begin
                     st_in.pending_command = rx_byte;
                     if (!is_confirm) begin
                        kind                = TX_ECHO;
                        txb                 = rx_byte;
                        st_in.request_open  = 1'b1;
                        st_in.wait_count    = 16'd0;
                     end
                  end else if (st_ff.config_mode) begin
                     if (is_confirm) begin
                        st_in.led_now    = (rx_byte == CHAR_T) ? LED_ALL_ON : LED_DARK;
                        st_in.hold_count = cfg.hold_ticks;
                        if (cfg.hold_ticks == 16'd0) begin
                           st_in.config_mode  = 1'b0;
                           st_in.request_open = 1'b0;
                           st_in.led_now      = {1'b0, st_ff.channel_bits};
                        end
                     end
                  end else if (rx_byte == CHAR_T) begin
                     if (pend_digit) begin
                        st_in.channel_bits = st_ff.pending_command[2:0];
                        st_in.led_now      = {1'b0, st_ff.pending_command[2:0]};
                        st_in.request_open = 1'b0;
                     end else if (st_ff.pending_command == CHAR_U) begin
                        kind = TX_STATUS;
                        txb  = {5'd0, st_ff.channel_bits};
                     end else begin
                        st_in.request_open = 1'b0;
                     end
                  end else if (rx_byte == CHAR_F) begin
                     st_in.request_open = 1'b0;
                  end
               end
            end
            ACT_PRESS: begin
               st_in.press_count = 16'd0;
               if (!st_ff.config_mode) begin
                  if (button != 2'd3) begin
                     st_in.channel_bits = st_ff.channel_bits ^ (3'b001 << button);
                  end
                  st_in.led_now = {1'b0, st_in.channel_bits};
               end
            end
            ACT_RELEASE: begin
               st_in.press_count = 16'd0;
               if (!st_ff.config_mode && (pressed_mask == 3'd0)) begin
                  kind = TX_STATUS;
                  txb  = {5'd0, st_ff.channel_bits};
               end
            end
            ACT_TICK: begin
               if (!st_ff.config_mode) begin
                  // Normal mode: confirm timeout and long press detection.
                  if (st_ff.request_open) begin
                     st_in.wait_count = wait_inc;
                     if (wait_inc >= cfg.confirm_timeout_ticks) begin
                        st_in.wait_count   = 16'd0;
                        st_in.request_open = 1'b0;
                     end
                  end
                  if (pressed_mask == 3'b110) begin
                     st_in.press_count = press_inc;
                     if (press_inc >= cfg.long_press_ticks) begin
                        st_in.press_count  = 16'd0;
                        kind               = TX_ANNOUNCE;
                        st_in.config_mode  = 1'b1;
                        st_in.request_open = 1'b1;
                        st_in.wait_count   = 16'd0;
                        st_in.led_now      = LED_DARK;
                        st_in.blink_phase  = 1'b0;
                        st_in.phase_ticks  = 16'd0;
                     end
                  end else begin
                     st_in.press_count = 16'd0;
                  end
               end else begin
                  // Config mode: two-speed wait count and blinking.
                  if (st_ff.request_open) begin
                     st_in.wait_count = wait_inc;
                     if (wait_inc > cfg.config_fast_ticks) begin
                        st_in.led_now    = LED_DARK;
                        st_in.wait_count = wait_inc2;
                        if (wait_inc2 >= cfg.config_exit_ticks) begin
                           st_in.wait_count   = 16'd0;
                           st_in.config_mode  = 1'b0;
                           st_in.request_open = 1'b0;
                           st_in.led_now      = {1'b0, st_ff.channel_bits};
                           exited             = 1'b1;
                        end
                     end
                  end
                  if (!exited) begin
                     st_in.phase_ticks = blink_inc;
                     st_in.led_now     = st_ff.blink_phase ? LED_BLINK : LED_DARK;
                     if (blink_inc >= cfg.blink_half_ticks) begin
                        st_in.phase_ticks = 16'd0;
                        st_in.blink_phase = !st_ff.blink_phase;
                     end
                  end
               end
            end
            default: st_in = st_ff;
         endcase
      end
   end

   // State advances only on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

   assign rsp.led_pattern   = st_in.led_now;
   assign rsp.relay_pattern = st_in.channel_bits;
   assign rsp.tx_kind       = kind;
   assign rsp.tx_byte       = txb;

   // A confirm hold only exists inside config mode.
   a_hold_in_config: assert property (@(posedge clock) disable iff (reset)
      (st_ff.hold_count != 16'd0) |-> st_ff.config_mode)
      else $error("hold active outside config mode");

   // Config mode always keeps its request open.
   a_config_open: assert property (@(posedge clock) disable iff (reset)
      st_ff.config_mode |-> st_ff.request_open)
      else $error("config mode without open request");

   // Entering config mode is always announced.
   a_config_announce: assert property (@(posedge clock) disable iff (reset)
      (step && !st_ff.config_mode && st_in.config_mode) |-> (kind == TX_ANNOUNCE))
      else $error("config mode entered without announce");

   // A status report carries a value of three bits.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      (kind == TX_STATUS) |-> (txb[7:3] == 5'd0))
      else $error("status report out of range");

endmodule

// ===== rtl/core/trsc_rsp_reg.sv =====
// Result register with stream handshake for the touch relay switch controller.
module trsc_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  trsc_pkg::rsp_type  rsp_next,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output trsc_pkg::rsp_type  rsp,
   output logic               space
);
   import trsc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Room for a new word when empty or when the held word leaves now.
   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = data_ff;

endmodule

// ===== rtl/core/touch_relay_switch_controller_unit.sv =====
// Top level of the touch relay switch controller.
//
//   Port group  Direction  Contents
//   req_*       in         one event word: action, serial byte, button, pressed mask
//   rsp_*       out        one result word per event: LEDs, relays, transmit kind and byte
//   csr_*       in         register writes, no read-back
//
// Every event is handled by the state update logic in the cycle it is presented and lands
// in the result register at the accepting edge, so one word per cycle is taken while the
// result register has room, and the result is offered in the cycle after acceptance.
// req_tready is low only while the result register holds a word that is not taken.
// Reset is synchronous; it clears all state and loads the register defaults.
module touch_relay_switch_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // rx_byte, button, pressed_mask
   input  logic [1:0]                          req_tuser,  // action
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // led_pattern, relay_pattern, tx_byte
   output logic [1:0]                          rsp_tuser,  // tx_kind
   input  logic                                csr_we,
   input  logic [trsc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [15:0]                         csr_wdata
);
   import trsc_pkg::*;

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_out;
   logic    space;
   logic    req_accept;

   assign req_tready = space;
   assign req_accept = req_tvalid && space;

   trsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   trsc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (req_accept),
      .action       (action_type'(req_tuser)),
      .rx_byte      (req_tdata[7:0]),
      .button       (req_tdata[9:8]),
      .pressed_mask (req_tdata[12:10]),
      .rsp          (rsp_next)
   );

   trsc_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .rsp_next   (rsp_next),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp        (rsp_out),
      .space      (space)
   );

   // Pack the result word.
   assign rsp_tdata = {1'b0, rsp_out.tx_byte, rsp_out.relay_pattern, rsp_out.led_pattern};
   assign rsp_tuser = rsp_out.tx_kind;

endmodule
